@@ design/bkvt_pkg.sv @@
// bkvt_pkg: types, codes and the control store program of the key-value table.
// Used by bkvt_store, bounded_key_value_table_core and bkvt_checker; no dependencies.
package bkvt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 32;
  localparam int LIMIT_W  = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_FIND = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_DUMP = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_DELETED   = 3'd6,
    ST_DUMP      = 3'd7
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [KEY_W-1:0]   key;
    logic signed [VAL_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   out_key;
    logic signed [VAL_W-1:0] out_value;
    logic               last;
  } out_item_t;

  // store port controls
  typedef struct packed {
    logic             wr_key_en;
    logic             wr_val_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } store_req_t;

  // micro program counter, one code per step
  typedef enum logic [4:0] {
    UP_IDLE,
    UP_ADD_CHK,
    UP_ADD_SCAN,
    UP_ADD_UPD,
    UP_ADD_INS,
    UP_ADD_FULL,
    UP_FIND_CHK,
    UP_FIND_SCAN,
    UP_FIND_HIT,
    UP_MISS,
    UP_DEL_CHK,
    UP_DEL_SCAN,
    UP_DEL_RDL,
    UP_DEL_MOVE,
    UP_DUMP_CHK,
    UP_DUMP_LOOP,
    UP_EMPTY
  } upc_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_ACCEPT,
    COND_CNT_ZERO,
    COND_FULL,
    COND_MATCH,
    COND_SCAN_END
  } cond_t;

  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_LAST
  } addr_sel_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC
  } idx_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_INS,
    WR_UPD,
    WR_MOVE
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    KSRC_ZERO,
    KSRC_REQ,
    KSRC_RD
  } ksrc_t;

  typedef enum logic [1:0] {
    VSRC_ZERO,
    VSRC_HIT,
    VSRC_RD
  } vsrc_t;

  typedef enum logic {
    LAST_ONE,
    LAST_END
  } last_sel_t;

  // one control word
  typedef struct packed {
    logic      in_rdy;
    logic      stay;
    cond_t     cond_a;
    upc_t      tgt_a;
    cond_t     cond_b;
    upc_t      tgt_b;
    addr_sel_t addr_sel;
    logic      rd_en;
    idx_op_t   idx_op;
    logic      slot_ld;
    wr_op_t    wr_op;
    cnt_op_t   cnt_op;
    logic      emit;
    status_t   status;
    ksrc_t     ksrc;
    vsrc_t     vsrc;
    last_sel_t last_sel;
  } ctrl_t;

  // entry step of each command
  function automatic upc_t dispatch(cmd_t cmd);
    upc_t pc;
    unique case (cmd)
      CMD_ADD:  pc = UP_ADD_CHK;
      CMD_FIND: pc = UP_FIND_CHK;
      CMD_DEL:  pc = UP_DEL_CHK;
      CMD_DUMP: pc = UP_DUMP_CHK;
      default:  pc = UP_IDLE;
    endcase
    return pc;
  endfunction

  // control store: the whole program
  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t w;
    w = '0;
    unique case (pc)
      UP_IDLE: begin
        w.in_rdy = 1'b1;
        w.stay   = 1'b1;
        w.cond_a = COND_ACCEPT;
        w.idx_op = IDX_CLR;
      end
      // add: full test first, then prime slot 0 read
      UP_ADD_CHK: begin
        w.cond_a = COND_FULL;     w.tgt_a = UP_ADD_FULL;
        w.cond_b = COND_CNT_ZERO; w.tgt_b = UP_ADD_INS;
        w.rd_en  = 1'b1;          w.idx_op = IDX_INC;
      end
      UP_ADD_SCAN: begin
        w.stay   = 1'b1;
        w.cond_a = COND_MATCH;    w.tgt_a = UP_ADD_UPD;
        w.cond_b = COND_SCAN_END; w.tgt_b = UP_ADD_INS;
        w.rd_en  = 1'b1;          w.idx_op = IDX_INC;
        w.slot_ld = 1'b1;
      end
      UP_ADD_UPD: begin
        w.cond_a = COND_ALWAYS;   w.tgt_a = UP_IDLE;
        w.wr_op  = WR_UPD;
        w.emit   = 1'b1;          w.status = ST_UPDATED;
      end
      UP_ADD_INS: begin
        w.cond_a = COND_ALWAYS;   w.tgt_a = UP_IDLE;
        w.wr_op  = WR_INS;        w.cnt_op = CNT_INC;
        w.emit   = 1'b1;          w.status = ST_INSERTED;
      end
      UP_ADD_FULL: begin
        w.cond_a = COND_ALWAYS;   w.tgt_a = UP_IDLE;
        w.emit   = 1'b1;          w.status = ST_FULL;
      end
      // find
      UP_FIND_CHK: begin
        w.cond_a = COND_CNT_ZERO; w.tgt_a = UP_MISS;
        w.rd_en  = 1'b1;          w.idx_op = IDX_INC;
      end
      UP_FIND_SCAN: begin
        w.stay   = 1'b1;
        w.cond_a = COND_MATCH;    w.tgt_a = UP_FIND_HIT;
        w.cond_b = COND_SCAN_END; w.tgt_b = UP_MISS;
        w.rd_en  = 1'b1;          w.idx_op = IDX_INC;
        w.slot_ld = 1'b1;
      end
      UP_FIND_HIT: begin
        w.cond_a = COND_ALWAYS;   w.tgt_a = UP_IDLE;
        w.emit   = 1'b1;          w.status = ST_FOUND;
        w.ksrc   = KSRC_REQ;      w.vsrc = VSRC_HIT;
      end
      UP_MISS: begin
        w.cond_a = COND_ALWAYS;   w.tgt_a = UP_IDLE;
        w.emit   = 1'b1;          w.status = ST_NOT_FOUND;
      end
      // delete: scan, read the last entry, move it into the hole
      UP_DEL_CHK: begin
        w.cond_a = COND_CNT_ZERO; w.tgt_a = UP_EMPTY;
        w.rd_en  = 1'b1;          w.idx_op = IDX_INC;
      end
      UP_DEL_SCAN: begin
        w.stay   = 1'b1;
        w.cond_a = COND_MATCH;    w.tgt_a = UP_DEL_RDL;
        w.cond_b = COND_SCAN_END; w.tgt_b = UP_MISS;
        w.rd_en  = 1'b1;          w.idx_op = IDX_INC;
        w.slot_ld = 1'b1;
      end
      UP_DEL_RDL: begin
        w.addr_sel = ADDR_LAST;   w.rd_en = 1'b1;
      end
      UP_DEL_MOVE: begin
        w.cond_a = COND_ALWAYS;   w.tgt_a = UP_IDLE;
        w.wr_op  = WR_MOVE;       w.cnt_op = CNT_DEC;
        w.emit   = 1'b1;          w.status = ST_DELETED;
      end
      // dump: one entry out per step
      UP_DUMP_CHK: begin
        w.cond_a = COND_CNT_ZERO; w.tgt_a = UP_EMPTY;
        w.rd_en  = 1'b1;          w.idx_op = IDX_INC;
      end
      UP_DUMP_LOOP: begin
        w.stay   = 1'b1;
        w.cond_a = COND_SCAN_END; w.tgt_a = UP_IDLE;
        w.rd_en  = 1'b1;          w.idx_op = IDX_INC;
        w.emit   = 1'b1;          w.status = ST_DUMP;
        w.ksrc   = KSRC_RD;       w.vsrc = VSRC_RD;
        w.last_sel = LAST_END;
      end
      UP_EMPTY: begin
        w.cond_a = COND_ALWAYS;   w.tgt_a = UP_IDLE;
        w.emit   = 1'b1;          w.status = ST_EMPTY;
      end
      default: begin
        w.cond_a = COND_ALWAYS;   w.tgt_a = UP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ design/bkvt_store.sv @@
// bkvt_store: key and value arrays with one write port and one registered read port.
// Depends on bkvt_pkg for widths and the store_req_t control struct.
module bkvt_store (
  input  logic                           clk,
  input  bkvt_pkg::store_req_t           req,
  input  logic [bkvt_pkg::KEY_W-1:0]     wr_key,
  input  logic [bkvt_pkg::VAL_W-1:0]     wr_val,
  output logic [bkvt_pkg::KEY_W-1:0]     rd_key,
  output logic [bkvt_pkg::VAL_W-1:0]     rd_val
);
  import bkvt_pkg::*;

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem [CAPACITY];
  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_key_en) begin
      key_mem[req.wr_addr] <= wr_key;
    end
    if (req.wr_val_en) begin
      val_mem[req.wr_addr] <= wr_val;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_key_r <= key_mem[req.rd_addr];
      rd_val_r <= val_mem[req.rd_addr];
    end
  end

  assign rd_key = rd_key_r;
  assign rd_val = rd_val_r;

endmodule

@@ design/bounded_key_value_table_core.sv @@
// bounded_key_value_table_core: microcoded key-value table with linear search.
// Depends on bkvt_pkg (types, program) and bkvt_store (entry arrays).
//
//   channel   direction  signals                    payload
//   in_       input      in_valid / in_ready        in_item_t  (cmd, key, entry_value)
//   out_      output     out_valid / out_ready      out_item_t (status, key, value, last)
//   cfg_      input      cfg_we                     capacity_limit, 5 bits
//
// add, find and delete run a check step, then a scan step per slot scanned (at most 16),
// and delete adds a step that reads the last entry; dump emits one entry per cycle
// while the output is not stalled.
// the rate is set by the single read port of the store, one slot per cycle while no result stalls.
// the idle step of the program counter takes the next transaction.
// rst_n empties the table and sets the limit to 16; entries need no clearing.
// a stalled result freezes the whole step until the output register frees up.
module bounded_key_value_table_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bkvt_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bkvt_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [bkvt_pkg::LIMIT_W-1:0] cfg_data
);
  import bkvt_pkg::*;

  upc_t                pc_r, pc_nxt;
  ctrl_t               cw;
  logic [LIMIT_W-1:0]  limit_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [IDX_W-1:0]    slot_r;
  logic [VAL_W-1:0]    hit_val_r;
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    val_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  store_req_t          sreq;
  logic [KEY_W-1:0]    wr_key, rd_key;
  logic [VAL_W-1:0]    wr_val, rd_val;

  logic [LIMIT_W-1:0]  limit_eff;
  logic                full, match, scan_end, stall, go, ca, cb;
  out_item_t           res;

  // control word of the current step
  assign cw = ucode(pc_r);

  // status flags
  assign limit_eff = (limit_r > LIMIT_W'(CAPACITY)) ? LIMIT_W'(CAPACITY) : limit_r;
  assign full      = ({{(LIMIT_W > CNT_W ? LIMIT_W - CNT_W : 0){1'b0}}, cnt_r} >= limit_eff);
  assign match     = (rd_key == key_r);
  assign scan_end  = ({1'b0, rd_idx_r} == CNT_W'(cnt_r - CNT_W'(1)));

  // an emitting step waits for the output register
  assign stall = cw.emit && out_valid_r && !out_ready;
  assign go    = !stall;

  assign in_ready = cw.in_rdy;

  // condition evaluation
  always_comb begin
    case (cw.cond_a)
      COND_ALWAYS:   ca = 1'b1;
      COND_ACCEPT:   ca = in_valid;
      COND_CNT_ZERO: ca = (cnt_r == '0);
      COND_FULL:     ca = full;
      COND_MATCH:    ca = match;
      COND_SCAN_END: ca = scan_end;
      default:       ca = 1'b0;
    endcase
    case (cw.cond_b)
      COND_ALWAYS:   cb = 1'b1;
      COND_ACCEPT:   cb = in_valid;
      COND_CNT_ZERO: cb = (cnt_r == '0);
      COND_FULL:     cb = full;
      COND_MATCH:    cb = match;
      COND_SCAN_END: cb = scan_end;
      default:       cb = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (!go) begin
      pc_nxt = pc_r;
    end else if (ca) begin
      pc_nxt = (cw.cond_a == COND_ACCEPT) ? dispatch(in_data.cmd) : cw.tgt_a;
    end else if (cb) begin
      pc_nxt = cw.tgt_b;
    end else if (cw.stay) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = upc_t'(pc_r + 5'd1);
    end
  end

  // scan index and live count
  always_comb begin
    idx_nxt = idx_r;
    if (go) begin
      case (cw.idx_op)
        IDX_CLR: idx_nxt = '0;
        IDX_INC: idx_nxt = idx_r + IDX_W'(1);
        default: idx_nxt = idx_r;
      endcase
    end
    cnt_nxt = cnt_r;
    if (go) begin
      case (cw.cnt_op)
        CNT_INC: cnt_nxt = cnt_r + CNT_W'(1);
        CNT_DEC: cnt_nxt = cnt_r - CNT_W'(1);
        default: cnt_nxt = cnt_r;
      endcase
    end
  end

  // store port controls
  always_comb begin
    sreq.rd_en   = cw.rd_en && go;
    sreq.rd_addr = (cw.addr_sel == ADDR_LAST) ? IDX_W'(cnt_r - CNT_W'(1)) : idx_r;
    sreq.wr_key_en = 1'b0;
    sreq.wr_val_en = 1'b0;
    sreq.wr_addr   = slot_r;
    wr_key = key_r;
    wr_val = val_r;
    case (cw.wr_op)
      WR_INS: begin
        sreq.wr_key_en = go;
        sreq.wr_val_en = go;
        sreq.wr_addr   = IDX_W'(cnt_r);
      end
      WR_UPD: begin
        sreq.wr_val_en = go;
      end
      WR_MOVE: begin
        sreq.wr_key_en = go;
        sreq.wr_val_en = go;
        wr_key = rd_key;
        wr_val = rd_val;
      end
      default: begin
        sreq.wr_key_en = 1'b0;
      end
    endcase
  end

  bkvt_store u_store (
    .clk    (clk),
    .req    (sreq),
    .wr_key (wr_key),
    .wr_val (wr_val),
    .rd_key (rd_key),
    .rd_val (rd_val)
  );

  // result assembly
  always_comb begin
    res.status = cw.status;
    case (cw.ksrc)
      KSRC_REQ: res.out_key = key_r;
      KSRC_RD:  res.out_key = rd_key;
      default:  res.out_key = '0;
    endcase
    case (cw.vsrc)
      VSRC_HIT: res.out_value = hit_val_r;
      VSRC_RD:  res.out_value = rd_val;
      default:  res.out_value = '0;
    endcase
    res.last = (cw.last_sel == LAST_END) ? scan_end : 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= UP_IDLE;
      cnt_r       <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (cw.emit && go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (in_valid && in_ready) begin
      key_r <= in_data.key;
      val_r <= in_data.entry_value;
    end
    if (sreq.rd_en) begin
      rd_idx_r <= sreq.rd_addr;
    end
    if (cw.slot_ld && go) begin
      slot_r    <= rd_idx_r;
      hit_val_r <= rd_val;
    end
    if (cw.emit && go) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/bkvt_checker.sv @@
// bkvt_checker: port-level assertions for the key-value table, bound to the top level.
// Depends on bkvt_pkg for payload types and status codes.
module bkvt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bkvt_pkg::out_item_t out_data
);
  import bkvt_pkg::*;

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // only a dump produces more than one result per transaction
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_DUMP) |-> out_data.last)
    else $error("non-dump result without last");

  // results other than found and dump carry zero key and value
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_FOUND) && (out_data.status != ST_DUMP)
      |-> (out_data.out_key == '0) && (out_data.out_value == '0))
    else $error("status-only result with nonzero payload");

  // a command is in progress right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

endmodule

bind bounded_key_value_table_core bkvt_checker u_bkvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
